>>> rtl/fpor_pkg.sv
// Package: shared types and constants for the finder pattern overlay renderer.
package fpor_pkg;

   localparam int CFG_W        = 48;
   localparam int CFG_IDX_W    = 2;
   localparam int NUM_PATTERNS = 3;
   localparam int GRAY_W       = 8;

   localparam logic [GRAY_W-1:0] GRAY_BLACK = 8'd0;
   localparam logic [GRAY_W-1:0] GRAY_WHITE = 8'd255;

   localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ZERO = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ONE  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TWO  = 2'd2;

   // Load enables of the three working stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // Per-pattern verdict for one pixel.
   typedef struct packed {
      logic hit;
      logic paint_black;
   } lane_out_type;

endpackage

>>> rtl/fpor_lane.sv
// Module: three-stage box test and module classification for one finder pattern.
module fpor_lane #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4
) (
   input  logic                         clock,
   input  fpor_pkg::stage_en_type       stage_en,
   input  logic [fpor_pkg::CFG_W-1:0]   cfg,
   input  logic [COORD_BITS-1:0]        pixel_x,
   input  logic [COORD_BITS-1:0]        pixel_y,
   output fpor_pkg::lane_out_type       result
);

   localparam int FW    = COORD_BITS + FRAC_BITS;
   localparam int SW    = FW + 5;
   localparam int EXT_W = 3 * FW + fpor_pkg::CFG_W;

   // Stage 1: decode the pattern register.
   logic [EXT_W-1:0]     cfg_ext;
   logic [FW-1:0]        cx, cy, ms;
   logic signed [SW-1:0] cx2, cy2, m1, m7;
   logic signed [SW-1:0] left_in, right_in, top_in, bot_in;
   logic signed [SW-1:0] t2_in, t4_in, t10_in, t12_in;

   assign cfg_ext  = {{(3 * FW){1'b0}}, cfg};
   assign cx       = cfg_ext[0 +: FW];
   assign cy       = cfg_ext[FW +: FW];
   assign ms       = cfg_ext[2 * FW +: FW];
   assign cx2      = $signed(SW'(cx)) <<< 1;
   assign cy2      = $signed(SW'(cy)) <<< 1;
   assign m1       = $signed(SW'(ms));
   assign m7       = (m1 <<< 3) - m1;
   assign left_in  = cx2 - m7;
   assign right_in = cx2 + m7;
   assign top_in   = cy2 - m7;
   assign bot_in   = cy2 + m7;
   assign t2_in    = m1 <<< 1;
   assign t4_in    = m1 <<< 2;
   assign t10_in   = (m1 <<< 3) + (m1 <<< 1);
   assign t12_in   = (m1 <<< 3) + (m1 <<< 2);

   logic                 on1_ff;
   logic signed [SW-1:0] left_ff, right_ff, top_ff, bot_ff;
   logic signed [SW-1:0] t2a_ff, t4a_ff, t10a_ff, t12a_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         on1_ff   <= (ms != '0);
         left_ff  <= left_in;
         right_ff <= right_in;
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         t2a_ff   <= t2_in;
         t4a_ff   <= t4_in;
         t10a_ff  <= t10_in;
         t12a_ff  <= t12_in;
      end
   end

   // Stage 2: box test and offset from the box start, in half-sub-pixel units.
   logic signed [SW-1:0] px_s, pnx_s, py_s, pny_s;
   logic                 in_x_in, in_y_in;
   logic signed [SW-1:0] dx_in, dy_in;

   assign px_s    = $signed(SW'(pixel_x)) <<< (FRAC_BITS + 1);
   assign pnx_s   = ($signed(SW'(pixel_x)) + $signed(SW'(1))) <<< (FRAC_BITS + 1);
   assign py_s    = $signed(SW'(pixel_y)) <<< (FRAC_BITS + 1);
   assign pny_s   = ($signed(SW'(pixel_y)) + $signed(SW'(1))) <<< (FRAC_BITS + 1);
   assign in_x_in = (pnx_s > left_ff) && (px_s <= right_ff);
   assign in_y_in = (pny_s > top_ff) && (py_s <= bot_ff);
   assign dx_in   = px_s - left_ff;
   assign dy_in   = py_s - top_ff;

   logic                 on2_ff, in_x_ff, in_y_ff;
   logic signed [SW-1:0] dx_ff, dy_ff;
   logic signed [SW-1:0] t2b_ff, t4b_ff, t10b_ff, t12b_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         on2_ff  <= on1_ff;
         in_x_ff <= in_x_in;
         in_y_ff <= in_y_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         t2b_ff  <= t2a_ff;
         t4b_ff  <= t4a_ff;
         t10b_ff <= t10a_ff;
         t12b_ff <= t12a_ff;
      end
   end

   // Stage 3: classify the module along each axis by threshold compares
   // (index 0 below 2m, index 6 from 12m, center band 4m up to 10m).
   logic x_edge, y_edge, x_mid, y_mid;
   fpor_pkg::lane_out_type result_in;

   assign x_edge = (dx_ff < t2b_ff) || (dx_ff >= t12b_ff);
   assign y_edge = (dy_ff < t2b_ff) || (dy_ff >= t12b_ff);
   assign x_mid  = (dx_ff >= t4b_ff) && (dx_ff < t10b_ff);
   assign y_mid  = (dy_ff >= t4b_ff) && (dy_ff < t10b_ff);

   assign result_in.hit         = on2_ff && in_x_ff && in_y_ff;
   assign result_in.paint_black = x_edge || y_edge || (x_mid && y_mid);

   fpor_pkg::lane_out_type result_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/finder_pattern_overlay_renderer_unit.sv
// Module: top level of the finder pattern overlay renderer pipeline.
//
//  channel  ports                                   direction  transfer when
//  -------  --------------------------------------  ---------  -------------------------
//  req      req_valid req_stall req_pixel_x/_y       in         req_valid && !req_stall
//           req_is_black
//  rsp      rsp_valid rsp_stall rsp_gray_level       out        rsp_valid && !rsp_stall
//  csr      csr_wr_en csr_index csr_wdata            in         csr_wr_en
//
// One pixel per cycle sustained while rsp is not stalled; four register
// stages (decode, box test, classify, merge/output), through which each
// pixel passes in that order after the request transfer.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles are squeezed out and a pixel is taken while a result waits.
// req_stall rises only when all four stages hold pixels and rsp is stalled.
// Reset (synchronous, active high) empties the pipeline and clears all three
// pattern registers, which disables every pattern.
module finder_pattern_overlay_renderer_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [COORD_BITS-1:0]             req_pixel_x,
   input  logic [COORD_BITS-1:0]             req_pixel_y,
   input  logic                              req_is_black,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fpor_pkg::GRAY_W-1:0]       rsp_gray_level,
   input  logic                              csr_wr_en,
   input  logic [fpor_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [fpor_pkg::CFG_W-1:0]        csr_wdata
);

   // ---------------------------------------------------------------
   // Pattern registers; an index past the last pattern is dropped.
   // ---------------------------------------------------------------
   logic [fpor_pkg::CFG_W-1:0] pattern_ff [fpor_pkg::NUM_PATTERNS];

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff[0] <= '0;
         pattern_ff[1] <= '0;
         pattern_ff[2] <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fpor_pkg::REG_PATTERN_ZERO: pattern_ff[0] <= csr_wdata;
            fpor_pkg::REG_PATTERN_ONE:  pattern_ff[1] <= csr_wdata;
            fpor_pkg::REG_PATTERN_TWO:  pattern_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage enables: a stage advances when empty or when its successor
   // advances. The output register advances when empty or transferred.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en_out;
   fpor_pkg::stage_en_type stage_en;

   assign en_out      = !rsp_valid_ff || !rsp_stall;
   assign stage_en.s3 = !v3_ff || en_out;
   assign stage_en.s2 = !v2_ff || stage_en.s3;
   assign stage_en.s1 = !v1_ff || stage_en.s2;
   assign req_stall   = !stage_en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_en.s1) v1_ff        <= req_valid;
         if (stage_en.s2) v2_ff        <= v1_ff;
         if (stage_en.s3) v3_ff        <= v2_ff;
         if (en_out)      rsp_valid_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Pixel payload travels alongside the lanes.
   // ---------------------------------------------------------------
   logic [COORD_BITS-1:0] px1_ff, py1_ff;
   logic                  blk1_ff, blk2_ff, blk3_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         px1_ff  <= req_pixel_x;
         py1_ff  <= req_pixel_y;
         blk1_ff <= req_is_black;
      end
      if (stage_en.s2) blk2_ff <= blk1_ff;
      if (stage_en.s3) blk3_ff <= blk2_ff;
   end

   // ---------------------------------------------------------------
   // One lane per pattern; all see the same pixel in lockstep.
   // ---------------------------------------------------------------
   fpor_pkg::lane_out_type lane_res [fpor_pkg::NUM_PATTERNS];

   for (genvar g = 0; g < fpor_pkg::NUM_PATTERNS; g++) begin : g_lane
      fpor_lane #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .cfg      (pattern_ff[g]),
         .pixel_x  (px1_ff),
         .pixel_y  (py1_ff),
         .result   (lane_res[g])
      );
   end

   // ---------------------------------------------------------------
   // Merge: later patterns override earlier ones; register the gray level.
   // ---------------------------------------------------------------
   logic merged_black;

   always_comb begin
      merged_black = blk3_ff;
      for (int i = 0; i < fpor_pkg::NUM_PATTERNS; i++) begin
         if (lane_res[i].hit) merged_black = lane_res[i].paint_black;
      end
   end

   logic [fpor_pkg::GRAY_W-1:0] gray_ff;

   always_ff @(posedge clock) begin
      if (en_out) begin
         gray_ff <= merged_black ? fpor_pkg::GRAY_BLACK : fpor_pkg::GRAY_WHITE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_level = gray_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Input backpressure only when the whole pipeline is full and rsp stalls.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   // With rsp free-flowing, a transferred pixel advances through every stage and reaches the output.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("accepted pixel did not reach the output on time");

   // A stalled stage three must mean the output register is full and held.
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !stage_en.s3) |-> (rsp_valid && rsp_stall))
      else $error("stage three held without output backpressure");

endmodule
